>>> hw/rtl/tfr_pkg.sv
// Shared types and constants for the telemetry frame receiver.
package tfr_pkg;

  localparam int MaxPayload = 64;
  localparam int AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'hAF;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_READ    = 3'd6,
    PH_SHOW    = 3'd7
  } phase_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

>>> hw/rtl/tfr_payload_ram.sv
// Payload store: one write port and one registered read port.
module tfr_payload_ram
  import tfr_pkg::*;
(
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem [MaxPayload];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/telemetry_frame_receiver.sv
// Top level of the telemetry frame receiver: parser, payload store and read-out.
//
//   channel   direction   handshake                 payload
//   in        into block  in_valid_i / in_ready_o   rx_byte_i
//   out       from block  out_valid_o / out_ready_i command_code_o, payload_length_o,
//                                                   byte_index_o, payload_byte_o,
//                                                   last_of_frame_o
//
// While parsing, one received byte is taken every cycle.
// After a good checksum, for a frame that fits the store, the block reads the frame
// out of the payload RAM: each result is read from the RAM, then shown until out_ready_i.
// During read-out in_ready_o is low; input stays blocked until the last result is taken.
// Reset is asynchronous and clears the parser state; the RAM contents are not cleared.
module telemetry_frame_receiver
  import tfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] command_code_o,
  output logic [6:0] payload_length_o,
  output logic [5:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       last_of_frame_o
);

  phase_e           phase_q, phase_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic [AddrW-1:0] idx_q, idx_d;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       in_fire;
  logic       is_last;

  tfr_payload_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rdata)
  );

  assign in_ready_o  = (phase_q != PH_READ) && (phase_q != PH_SHOW);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (phase_q == PH_SHOW);

  assign is_last = (len_q == 8'd0) || ((8'(idx_q) + 8'd1) == len_q);

  assign command_code_o   = cmd_q;
  assign payload_length_o = len_q[6:0];
  assign byte_index_o     = 6'(idx_q);
  assign payload_byte_o   = (len_q == 8'd0) ? 8'd0 : ram_rdata;
  assign last_of_frame_o  = is_last;

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    idx_d   = idx_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = cnt_q[AddrW-1:0];
    ram_req.wdata = rx_byte_i;
    ram_req.re    = 1'b0;
    ram_req.raddr = idx_q;

    case (phase_q)
      PH_HUNT: begin
        if (in_fire && rx_byte_i == HdrFirst) begin
          sum_d   = rx_byte_i;
          phase_d = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (in_fire) begin
          if (rx_byte_i == HdrSecond) begin
            sum_d   = sum_q + rx_byte_i;
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      end
      PH_CMD: begin
        if (in_fire) begin
          cmd_d   = rx_byte_i;
          sum_d   = sum_q + rx_byte_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (in_fire) begin
          len_d   = rx_byte_i;
          sum_d   = sum_q + rx_byte_i;
          cnt_d   = 8'd0;
          phase_d = (rx_byte_i == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (in_fire) begin
          // Bytes past the store size are summed and counted but not kept.
          ram_req.we = (cnt_q < 8'(MaxPayload));
          sum_d      = sum_q + rx_byte_i;
          cnt_d      = cnt_q + 8'd1;
          if ((cnt_q + 8'd1) == len_q) begin
            phase_d = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (in_fire) begin
          idx_d = '0;
          if (rx_byte_i == sum_q && len_q <= 8'(MaxPayload)) begin
            phase_d = PH_READ;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      end
      PH_READ: begin
        ram_req.re = 1'b1;
        phase_d    = PH_SHOW;
      end
      PH_SHOW: begin
        if (out_ready_i) begin
          if (is_last) begin
            phase_d = PH_HUNT;
          end else begin
            idx_d   = idx_q + 1'b1;
            phase_d = PH_READ;
          end
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cmd_q   <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      sum_q   <= 8'd0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
    end
  end

  // A result is only shown right after its RAM read or while it waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SHOW |-> $past(phase_q) == PH_READ || $past(phase_q) == PH_SHOW)
    else $error("result shown without a preceding RAM read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_READ |=> phase_q == PH_SHOW)
    else $error("RAM read not followed by the output stage");

  // Read-out only happens for frames that fit in the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> len_q <= 8'(MaxPayload) && !in_ready_o)
    else $error("read-out of an oversized frame or with input open");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && len_q != 8'd0 |-> 8'(idx_q) < len_q)
    else $error("read-out index past frame length");

endmodule

>>> dv/tb_telemetry_frame_receiver.sv
// Self-checking testbench for the telemetry frame receiver, with a byte-level frame predictor.
module tb_telemetry_frame_receiver;
  import tfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldOffCycles = 300;
  localparam int ItemTarget    = 420;
  localparam int CalmFrom      = 360;

  typedef struct packed {
    logic [7:0] command;
    logic [6:0] length;
    logic [5:0] index;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  // Tracks the parser state byte by byte and holds the payload bytes still owed by the block.
  class frame_tracker;
    phase_e          phase = PH_HUNT;
    logic [7:0]      frame_cmd = '0;
    logic [7:0]      frame_len = '0;
    logic [7:0]      byte_count = '0;
    logic [7:0]      running_sum = '0;
    logic [7:0]      payload_copy [MaxPayload];
    frame_result_t   payload_due [$];
    int              mismatches = 0;

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void take_byte(logic [7:0] b);
      case (phase)
        PH_HDR2: begin
          if (b == HdrSecond) begin
            running_sum += b;
            phase = PH_CMD;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_CMD: begin
          frame_cmd = b;
          running_sum += b;
          phase = PH_LEN;
        end
        PH_LEN: begin
          frame_len = b;
          running_sum += b;
          byte_count = '0;
          phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          // Oversized frames are still summed, but only the first bytes fit the store.
          if (byte_count < MaxPayload) payload_copy[byte_count] = b;
          running_sum += b;
          byte_count++;
          if (byte_count == frame_len) phase = PH_CHECK;
        end
        PH_CHECK: begin
          if (b == running_sum && frame_len <= MaxPayload) begin
            if (frame_len == 8'd0) begin
              payload_due.push_back(frame_result_t'{frame_cmd, 7'd0, 6'd0, 8'd0, 1'b1});
            end else begin
              for (int k = 0; k < frame_len; k++) begin
                payload_due.push_back(frame_result_t'{frame_cmd, frame_len[6:0], k[5:0],
                                                      payload_copy[k], k == frame_len - 1});
              end
            end
          end
          phase = PH_HUNT;
        end
        default: begin
          if (b == HdrFirst) begin
            running_sum = b;
            phase = PH_HDR2;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    task check_result(frame_result_t got);
      frame_result_t want;
      if (payload_due.size() == 0) begin
        report_mismatch($sformatf("result cmd=0x%0h idx=%0d with nothing pending",
                                  got.command, got.index));
        return;
      end
      want = payload_due.pop_front();
      if (got.command != want.command)
        report_mismatch($sformatf("command_code expected 0x%0h got 0x%0h",
                                  want.command, got.command));
      if (got.length != want.length)
        report_mismatch($sformatf("payload_length expected %0d got %0d",
                                  want.length, got.length));
      if (got.index != want.index)
        report_mismatch($sformatf("byte_index expected %0d got %0d", want.index, got.index));
      if (got.data != want.data)
        report_mismatch($sformatf("payload_byte at %0d expected 0x%0h got 0x%0h",
                                  want.index, want.data, got.data));
      if (got.last != want.last)
        report_mismatch($sformatf("last_of_frame at %0d expected %0b got %0b",
                                  want.index, want.last, got.last));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] command_code_o;
  logic [6:0] payload_length_o;
  logic [5:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic       last_of_frame_o;

  frame_tracker tracker = new();
  bit           idle_on = 1'b1;
  bit           hold_off_req = 1'b0;
  int           bytes_sent = 0;

  telemetry_frame_receiver uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .command_code_o,
    .payload_length_o,
    .byte_index_o,
    .payload_byte_o,
    .last_of_frame_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Outputs are checked before the input of the same edge is taken; a byte never
  // produces a result in the cycle it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_result(frame_result_t'{command_code_o, payload_length_o, byte_index_o,
                                             payload_byte_o, last_of_frame_o});
      end
      if (in_valid_i && in_ready_o) tracker.take_byte(rx_byte_i);
    end
  end

  // Receiver side: random stalls, plus a long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = HdrFirst + HdrSecond + cmd + len;
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_byte(cmd);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      sum += b;
      send_byte(b);
    end
    if (bad_sum) sum += 8'($urandom_range(1, 255));
    send_byte(sum);
    bytes_sent += 5 + len;
  endtask

  initial begin
    int         pick;
    int         noise_count;
    logic [7:0] b;
    logic [7:0] len;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: line noise at both extremes, an empty frame, a two-byte frame
    // with extreme payload, a checksum mismatch, and a bad second header byte that
    // must not be taken as a new first header byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h5A, 8'd0, 1'b0);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h59);
    send_frame(8'h01, 8'd1, 1'b1);
    // A block that re-examined the second 0xAA would see a valid empty frame here.
    send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h59);
    bytes_sent += 15;

    // A full-size frame read out against a long receiver hold-off, with the next
    // frame already waiting at the input.
    hold_off_req = 1'b1;
    send_frame(8'($urandom), 8'(MaxPayload), 1'b0);

    while (bytes_sent < ItemTarget) begin
      if (bytes_sent >= CalmFrom) idle_on = 1'b0;
      if (bytes_sent >= 200 && bytes_sent < 215) hold_off_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_frame(8'($urandom), 8'(MaxPayload), 1'b0);
      end else if (pick < 8) begin
        len = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(MaxPayload + 1, 72));
        send_frame(8'($urandom), len, 1'($urandom_range(0, 1)));
      end else if (pick < 16) begin
        send_frame(8'($urandom), 8'($urandom_range(0, 10)), 1'b1);
      end else if (pick < 24) begin
        // Noise between frames; the parser simply keeps hunting.
        noise_count = $urandom_range(1, 3);
        repeat (noise_count) send_byte(8'($urandom));
        bytes_sent += noise_count;
      end else if (pick < 30) begin
        b = 8'($urandom);
        if (b == HdrSecond) b = 8'h00;
        send_byte(HdrFirst);
        send_byte(b);
        bytes_sent += 2;
      end else begin
        send_frame(8'($urandom), 8'($urandom_range(0, 10)), 1'b0);
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.payload_due.size() != 0) @(posedge clk_i);
    repeat (2 * MaxPayload + 20) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
